// File: hw/rtl/service_handle_table_defines.svh
// ----------------------------------------------------------------------------
// service handle table assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SERVICE_HANDLE_TABLE_DEFINES_SVH
`define SERVICE_HANDLE_TABLE_DEFINES_SVH

// same-cycle implication
`define SHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// widths, codes and shared types of the service handle table
// ----------------------------------------------------------------------------
package sht_pkg;

  localparam int SLOTS_DEF  = 256;

  localparam int IREF_W     = 32;
  localparam int HANDLE_W   = 32;
  localparam int SERVICE_W  = 64;
  localparam int CORE_W     = 8;
  localparam int CORE_OUT_W = 24;
  localparam int STATUS_W   = 3;

  localparam int IN_DATA_W  = HANDLE_W + SERVICE_W + IREF_W;
  localparam int OUT_DATA_W = IREF_W + CORE_OUT_W + HANDLE_W + SERVICE_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LOCAL_CORE = 1'b0;

  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRONG_CORE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL_HANDLE = 3'd4;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: hw/rtl/sht_div.sv
// ----------------------------------------------------------------------------
// sht_div
// divides a 32-bit value by the table depth with a reciprocal multiply
// ----------------------------------------------------------------------------
module sht_div #(
  parameter int SLOTS = sht_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sht_pkg::IREF_W-1:0] dividend,
  output logic [sht_pkg::IREF_W-1:0] quot,
  output logic [AW-1:0]              rem,
  output logic                       done
);

  localparam int W  = sht_pkg::IREF_W;
  localparam int PW = 2 * W;
  // floor(2^32 / depth), the quotient estimate is low by at most one
  localparam logic [PW-1:0] RECIP_WIDE = (PW'(1) << W) / PW'(SLOTS);
  localparam logic [W-1:0]  RECIP      = RECIP_WIDE[W-1:0];
  localparam logic [W-1:0]  DIVISOR    = W'(SLOTS);

  logic [W-1:0]  t_r;
  logic [PW-1:0] prod_r;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [2:0]    step_r;
  logic          done_r;

  // step 1: estimate and partial remainder, step 2: one correction
  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    if (step_r[1]) begin
      q_nxt = prod_r[PW-1:W];
      r_nxt = t_r - prod_r[PW-1:W] * DIVISOR;
    end else if (step_r[2] && (r_r >= DIVISOR)) begin
      q_nxt = q_r + W'(1);
      r_nxt = r_r - DIVISOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= {step_r[1:0], start};
      done_r <= step_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= dividend;
    end
    if (step_r[0]) begin
      prod_r <= {{W{1'b0}}, t_r} * {{W{1'b0}}, RECIP};
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign quot = q_r;
  assign rem  = r_r[AW-1:0];
  assign done = done_r;

endmodule

// File: hw/rtl/sht_store.sv
// ----------------------------------------------------------------------------
// sht_store
// slot memories for handles and service values, one write and one read port
// ----------------------------------------------------------------------------
module sht_store #(
  parameter int SLOTS = sht_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic                          clk,
  input  sht_pkg::mem_ctl_t             ctl,
  input  logic [AW-1:0]                 waddr,
  input  logic [sht_pkg::HANDLE_W-1:0]  whandle,
  input  logic [sht_pkg::SERVICE_W-1:0] wservice,
  input  logic [AW-1:0]                 raddr,
  output logic [sht_pkg::HANDLE_W-1:0]  rhandle,
  output logic [sht_pkg::SERVICE_W-1:0] rservice
);

  logic [sht_pkg::HANDLE_W-1:0]  handle_mem [SLOTS];
  logic [sht_pkg::SERVICE_W-1:0] service_mem [SLOTS];
  logic [sht_pkg::HANDLE_W-1:0]  rhandle_r;
  logic [sht_pkg::SERVICE_W-1:0] rservice_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      handle_mem[waddr]  <= whandle;
      service_mem[waddr] <= wservice;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rhandle_r  <= handle_mem[raddr];
      rservice_r <= service_mem[raddr];
    end
  end

  assign rhandle  = rhandle_r;
  assign rservice = rservice_r;

endmodule

// File: hw/rtl/service_handle_table.sv
// ----------------------------------------------------------------------------
// service_handle_table
// per-core table of service handles with allocate and lookup requests
// ----------------------------------------------------------------------------
// usage:
//   in_*  takes one request at a time. in_tuser is the op (0 allocate,
//         1 lookup). an allocate stores a nonzero handle in the lowest free
//         slot and answers with SLOTS*local_core + slot + 1.
//   out_* returns one result per request, status on out_tuser.
//   cfg_* is an apb-style port holding local_core at byte address 0.
// sequence:
//   allocate: the request goes to S_ALLOC, which writes the result register
//             and returns to idle once the output is free.
//   lookup:   the request passes the divider (S_DIV), the core check (S_CHK)
//             and the registered slot read (S_RD); a wrong core or an unused slot answers from S_CHK.
// reset: a fill count marks the used slots (taken in order, never freed);
//   reset zeroes it and the table reads empty at once, no clear pass.
// stall: the result register holds while out_tready is low; the next
//   request is still taken and waits at its final step until it frees up.
// ----------------------------------------------------------------------------
`include "service_handle_table_defines.svh"

module service_handle_table #(
  parameter int SLOTS = sht_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // binding_handle[31:0], service_value[95:32], lookup_iref[127:96]
  input  logic [sht_pkg::IN_DATA_W-1:0]    in_tdata,
  // op[0]
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // new_iref[31:0], core_of_iref[55:32], found_handle[87:56],
  // found_service[151:88]
  output logic [sht_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  output logic [sht_pkg::STATUS_W-1:0]     out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sht_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sht_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sht_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  localparam int AW      = $clog2(SLOTS);
  localparam int CW      = $clog2(SLOTS + 1);
  localparam int STATE_W = 3;

  localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] S_ALLOC = 3'd1;
  localparam logic [STATE_W-1:0] S_DIV   = 3'd2;
  localparam logic [STATE_W-1:0] S_CHK   = 3'd3;
  localparam logic [STATE_W-1:0] S_RD    = 3'd4;

  localparam logic [sht_pkg::CFG_ADDR_W-3:0] REG_SEL =
    (sht_pkg::CFG_ADDR_W-2)'(sht_pkg::REG_LOCAL_CORE);

  logic [STATE_W-1:0]             state_r, state_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [sht_pkg::CORE_W-1:0]     local_core_r;
  logic [sht_pkg::HANDLE_W-1:0]   handle_r;
  logic [sht_pkg::SERVICE_W-1:0]  service_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [sht_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [sht_pkg::IREF_W-1:0]     out_iref_r, out_iref_nxt;
  logic [sht_pkg::CORE_OUT_W-1:0] out_core_r, out_core_nxt;
  logic [sht_pkg::HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic [sht_pkg::SERVICE_W-1:0]  out_service_r, out_service_nxt;

  logic                           in_acc;
  logic                           out_free;
  logic                           cfg_wr;
  logic                           cfg_sel_core;
  logic                           div_start;
  logic [sht_pkg::IREF_W-1:0]     div_quot;
  logic [AW-1:0]                  div_rem;
  logic                           div_done;
  logic                           core_hit;
  logic                           slot_used;
  logic                           table_full;
  logic [sht_pkg::IREF_W-1:0]     alloc_iref;
  sht_pkg::mem_ctl_t              mem_ctl;
  logic [sht_pkg::HANDLE_W-1:0]   rd_handle;
  logic [sht_pkg::SERVICE_W-1:0]  rd_service;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // configuration
  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel_core = (cfg_paddr[sht_pkg::CFG_ADDR_W-1:2] == REG_SEL);
  assign cfg_prdata   = cfg_sel_core ? sht_pkg::CFG_DATA_W'(local_core_r) : '0;

  // lookup decode: identifier minus one, divided by the depth
  assign div_start = in_acc && (in_tuser == sht_pkg::OP_LOOKUP);

  sht_div #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_tdata[sht_pkg::IN_DATA_W-1 -: sht_pkg::IREF_W] - 32'd1),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  sht_store #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .ctl      (mem_ctl),
    .waddr    (cnt_r[AW-1:0]),
    .whandle  (handle_r),
    .wservice (service_r),
    .raddr    (div_rem),
    .rhandle  (rd_handle),
    .rservice (rd_service)
  );

  assign core_hit   = (div_quot == sht_pkg::IREF_W'(local_core_r));
  assign slot_used  = (CW'(div_rem) < cnt_r);
  assign table_full = (cnt_r == CW'(SLOTS));
  assign alloc_iref = 32'(SLOTS) * sht_pkg::IREF_W'(local_core_r)
                    + sht_pkg::IREF_W'(cnt_r) + 32'd1;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    mem_ctl         = '0;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_iref_nxt    = out_iref_r;
    out_core_nxt    = out_core_r;
    out_handle_nxt  = out_handle_r;
    out_service_nxt = out_service_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == sht_pkg::OP_LOOKUP) ? S_DIV : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_iref_nxt    = '0;
          out_core_nxt    = '0;
          out_handle_nxt  = '0;
          out_service_nxt = '0;
          if (handle_r == '0) begin
            out_status_nxt = sht_pkg::ST_NULL_HANDLE;
          end else if (table_full) begin
            out_status_nxt = sht_pkg::ST_FULL;
          end else begin
            out_status_nxt = sht_pkg::ST_OK;
            out_iref_nxt   = alloc_iref;
            mem_ctl.we     = 1'b1;
            cnt_nxt        = cnt_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (core_hit && slot_used) begin
          mem_ctl.re = 1'b1;
          state_nxt  = S_RD;
        end else if (out_free) begin
          // wrong core, or a slot past the fill count that still reads empty
          out_valid_nxt   = 1'b1;
          out_status_nxt  = core_hit ? sht_pkg::ST_EMPTY : sht_pkg::ST_WRONG_CORE;
          out_iref_nxt    = '0;
          out_core_nxt    = div_quot[sht_pkg::CORE_OUT_W-1:0];
          out_handle_nxt  = '0;
          out_service_nxt = '0;
          state_nxt       = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = (rd_handle == '0) ? sht_pkg::ST_EMPTY : sht_pkg::ST_OK;
          out_iref_nxt    = '0;
          out_core_nxt    = div_quot[sht_pkg::CORE_OUT_W-1:0];
          out_handle_nxt  = rd_handle;
          out_service_nxt = rd_service;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      local_core_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_sel_core) begin
        local_core_r <= cfg_pwdata[sht_pkg::CORE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_iref_r    <= out_iref_nxt;
    out_core_r    <= out_core_nxt;
    out_handle_r  <= out_handle_nxt;
    out_service_r <= out_service_nxt;
    if (in_acc) begin
      handle_r  <= in_tdata[sht_pkg::HANDLE_W-1:0];
      service_r <= in_tdata[sht_pkg::HANDLE_W +: sht_pkg::SERVICE_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_service_r, out_handle_r, out_core_r, out_iref_r};

  `SHT_ASSERT_IMP(a_fill_bound, 1'b1, cnt_r <= CW'(SLOTS), "fill count beyond table depth")
  `SHT_ASSERT_IMP(a_write_ok, mem_ctl.we, (handle_r != '0) && !table_full, "bad slot write")
  `SHT_ASSERT_NXT(a_accept_busy, in_acc, state_r != S_IDLE, "request taken but no work started")
  `SHT_ASSERT_IMP(a_div_owner, div_done, state_r == S_DIV, "divider finished outside lookup")

endmodule
